>>> rtl/core/hpq_pkg.sv
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types and constants of the binary max-heap priority queue: entry
// layout, operation codes and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package hpq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 7;
  localparam int unsigned ENTRY_W = 2 * DATA_W;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic load_ins;
    logic cap_last;
    logic rd_parent;
    logic rd_last;
    logic up_move;
    logic dn_move;
    logic place;
    logic inc;
    logic dec;
    logic report;
    logic acc;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic up_gt;
    logic kid_none;
    logic dn_gt;
  } sts_t;

endpackage

>>> rtl/core/hpq_ram.sv
// ----------------------------------------------------------------------------
// hpq_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module hpq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  output logic [WIDTH-1:0]         rdata0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

>>> rtl/core/hpq_datapath.sv
// ----------------------------------------------------------------------------
// hpq_datapath
// Heap storage, entry count, hole position, moving entry, root copy and
// result registers. Acts on commands from the controller.
// ----------------------------------------------------------------------------
module hpq_datapath #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hpq_pkg::cmd_t                       cmd,
  output hpq_pkg::sts_t                       sts,
  input  logic signed [hpq_pkg::DATA_W-1:0]   in_item_value,
  input  logic signed [hpq_pkg::DATA_W-1:0]   in_item_priority,
  output logic                                out_strobe,
  output logic                                out_accepted,
  output logic                                out_top_valid,
  output logic signed [hpq_pkg::DATA_W-1:0]   out_top_value,
  output logic signed [hpq_pkg::DATA_W-1:0]   out_top_priority,
  output logic [hpq_pkg::OCC_W-1:0]           out_occupancy
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  hpq_pkg::entry_t       key_r, key_nxt;
  hpq_pkg::entry_t       root_r;

  logic                  we;
  logic [AW-1:0]         waddr;
  hpq_pkg::entry_t       wdata;
  logic [AW-1:0]         raddr0;
  hpq_pkg::entry_t       rd0;
  hpq_pkg::entry_t       rd1;

  logic [AW-1:0]         parent;
  logic [CW:0]           left_w;
  logic [CW:0]           right_w;
  logic                  right_ok;
  logic                  pick_right;
  hpq_pkg::entry_t       chosen;
  logic [AW-1:0]         chosen_idx;

  logic                  out_strobe_r;
  logic                  out_accepted_r;
  logic                  out_top_valid_r;
  hpq_pkg::entry_t       out_top_r;
  logic [hpq_pkg::OCC_W-1:0] out_occ_r;

  hpq_ram #(
    .WIDTH (hpq_pkg::ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (raddr0),
    .rdata0 (rd0),
    .raddr1 (right_w[AW-1:0]),
    .rdata1 (rd1)
  );

  assign parent     = (pos_r - AW'(1)) >> 1;
  assign left_w     = ((CW + 1)'(pos_r) << 1) | (CW + 1)'(1);
  assign right_w    = left_w + (CW + 1)'(1);
  assign right_ok   = right_w < (CW + 1)'(cnt_r);
  assign pick_right = right_ok && (rd1.prio > rd0.prio);
  assign chosen     = pick_right ? rd1 : rd0;
  assign chosen_idx = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];

  assign sts.full     = cnt_r >= CW'(CAPACITY);
  assign sts.empty    = cnt_r == '0;
  assign sts.pos_zero = pos_r == '0;
  assign sts.up_gt    = key_r.prio > rd0.prio;
  assign sts.kid_none = left_w >= (CW + 1)'(cnt_r);
  assign sts.dn_gt    = chosen.prio > key_r.prio;

  always_comb begin
    we      = 1'b0;
    waddr   = pos_r;
    wdata   = key_r;
    raddr0  = left_w[AW-1:0];
    pos_nxt = pos_r;
    key_nxt = key_r;
    cnt_nxt = cnt_r;
    if (cmd.rd_parent) begin
      raddr0 = parent;
    end else if (cmd.rd_last) begin
      raddr0 = AW'(cnt_r - CW'(1));
    end
    if (cmd.load_ins) begin
      pos_nxt = AW'(cnt_r);
      key_nxt = '{value: in_item_value, prio: in_item_priority};
    end
    if (cmd.cap_last) begin
      pos_nxt = '0;
      key_nxt = rd0;
    end
    if (cmd.up_move) begin
      we      = 1'b1;
      wdata   = rd0;
      pos_nxt = parent;
    end
    if (cmd.dn_move) begin
      we      = 1'b1;
      wdata   = chosen;
      pos_nxt = chosen_idx;
    end
    if (cmd.place) begin
      we    = 1'b1;
      wdata = key_r;
    end
    if (cmd.inc) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.dec) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      out_strobe_r <= cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    key_r <= key_nxt;
    if (we && waddr == '0) begin
      root_r <= wdata;
    end
    if (cmd.report) begin
      out_accepted_r  <= cmd.acc;
      out_top_valid_r <= !sts.empty;
      out_top_r       <= sts.empty ? '0 : root_r;
      out_occ_r       <= hpq_pkg::OCC_W'(cnt_r);
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_accepted     = out_accepted_r;
  assign out_top_valid    = out_top_valid_r;
  assign out_top_value    = out_top_r.value;
  assign out_top_priority = out_top_r.prio;
  assign out_occupancy    = out_occ_r;

endmodule

>>> rtl/core/hpq_ctrl.sv
// ----------------------------------------------------------------------------
// hpq_ctrl
// Controller state machine: sequences sift-up for insert and sift-down for
// remove-top, each heap level in a check state and a compare state, then reports the transaction.
// ----------------------------------------------------------------------------
module hpq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_operation,
  output logic          busy,
  input  hpq_pkg::sts_t sts,
  output hpq_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_RM_RD,
    S_RM_CAP,
    S_DN_CHK,
    S_DN_CMP,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   acc_r, acc_nxt;

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    cmd       = '0;
    cmd.acc   = acc_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_operation == hpq_pkg::OP_INSERT) begin
            if (sts.full) begin
              acc_nxt   = 1'b0;
              state_nxt = S_FIN;
            end else begin
              acc_nxt      = 1'b1;
              cmd.load_ins = 1'b1;
              state_nxt    = S_UP_CHK;
            end
          end else begin
            if (sts.empty) begin
              acc_nxt   = 1'b0;
              state_nxt = S_FIN;
            end else begin
              acc_nxt   = 1'b1;
              state_nxt = S_RM_RD;
            end
          end
        end
      end
      S_UP_CHK: begin
        if (sts.pos_zero) begin
          cmd.place = 1'b1;
          cmd.inc   = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.rd_parent = 1'b1;
          state_nxt     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_gt) begin
          cmd.up_move = 1'b1;
          state_nxt   = S_UP_CHK;
        end else begin
          cmd.place = 1'b1;
          cmd.inc   = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_RM_RD: begin
        cmd.rd_last = 1'b1;
        cmd.dec     = 1'b1;
        state_nxt   = S_RM_CAP;
      end
      S_RM_CAP: begin
        if (sts.empty) begin
          state_nxt = S_FIN;
        end else begin
          cmd.cap_last = 1'b1;
          state_nxt    = S_DN_CHK;
        end
      end
      S_DN_CHK: begin
        if (sts.kid_none) begin
          cmd.place = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (sts.dn_gt) begin
          cmd.dn_move = 1'b1;
          state_nxt   = S_DN_CHK;
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.report = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      acc_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule

>>> rtl/core/binary_max_heap_priority_queue_unit.sv
// From the accepting edge to out_strobe: insert climbs the new entry from the last slot,
// each level a parent read then a compare, while it beats its parent, then places it;
// remove-top moves the last entry to the root and sinks it, each level a child check then
// a compare, while its larger child beats it; a remove that empties the heap skips the
// sinking and a reject goes straight to the report. busy is low while out_strobe is high.
// Reset (rst_n low, synchronous) empties the queue; RAM contents stay as is.
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_unit
// Max-priority queue of (value, priority) pairs held as a binary heap in RAM.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_operation,
  input  logic signed [hpq_pkg::DATA_W-1:0] in_item_value,
  input  logic signed [hpq_pkg::DATA_W-1:0] in_item_priority,
  output logic                              out_strobe,
  output logic                              out_accepted,
  output logic                              out_top_valid,
  output logic signed [hpq_pkg::DATA_W-1:0] out_top_value,
  output logic signed [hpq_pkg::DATA_W-1:0] out_top_priority,
  output logic [hpq_pkg::OCC_W-1:0]         out_occupancy
);

  hpq_pkg::cmd_t cmd;
  hpq_pkg::sts_t sts;

  hpq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .busy         (busy),
    .sts          (sts),
    .cmd          (cmd)
  );

  hpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_strobe       (out_strobe),
    .out_accepted     (out_accepted),
    .out_top_valid    (out_top_valid),
    .out_top_value    (out_top_value),
    .out_top_priority (out_top_priority),
    .out_occupancy    (out_occupancy)
  );

endmodule

>>> rtl/core/hpq_checker.sv
// ----------------------------------------------------------------------------
// hpq_checker
// Port-level checks of the priority queue: transaction sequencing and the
// empty-heap result encoding.
// ----------------------------------------------------------------------------
module hpq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_strobe,
  input logic                              out_top_valid,
  input logic signed [hpq_pkg::DATA_W-1:0] out_top_value,
  input logic signed [hpq_pkg::DATA_W-1:0] out_top_priority,
  input logic [hpq_pkg::OCC_W-1:0]         out_occupancy
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_done_reports: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_strobe)
    else $error("transaction finished without a result");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_top_valid |->
      out_top_value == '0 && out_top_priority == '0 && out_occupancy == '0)
    else $error("empty heap result carries nonzero fields");

endmodule

bind binary_max_heap_priority_queue_unit hpq_checker u_hpq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_top_valid    (out_top_valid),
  .out_top_value    (out_top_value),
  .out_top_priority (out_top_priority),
  .out_occupancy    (out_occupancy)
);
